### sv/fvc_pkg.sv
// Shared types, codes and sizes for the FIFO victim cache.
// No dependencies; all other files refer to this package by scoped names.
package fvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_BITS   = 48;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SHIFT = 2'd2;

    // Request kinds
    localparam logic [3:0] KIND_READ        = 4'd0;
    localparam logic [3:0] KIND_WRITE       = 4'd1;
    localparam logic [3:0] KIND_UPGRADE     = 4'd2;
    localparam logic [3:0] KIND_EVICT_CLEAN = 4'd3;
    localparam logic [3:0] KIND_EVICT_WR    = 4'd4;
    localparam logic [3:0] KIND_EVICT_DIRTY = 4'd5;
    localparam logic [3:0] KIND_RETURN      = 4'd6;
    localparam logic [3:0] KIND_DOWNGRADE   = 4'd7;
    localparam logic [3:0] KIND_INVALIDATE  = 4'd8;
    localparam logic [3:0] KIND_PURGE_INSTR = 4'd9;
    localparam logic [3:0] KIND_PURGE_DATA  = 4'd10;

    // Reply messages beyond the pass-through kinds
    localparam logic [4:0] MSG_UPGRADE      = 5'd2;
    localparam logic [4:0] MSG_EVICT_CLEAN  = 5'd3;
    localparam logic [4:0] MSG_EVICT_DIRTY  = 5'd5;
    localparam logic [4:0] MSG_MISS_REPLY   = 5'd11;
    localparam logic [4:0] MSG_MISS_DIRTY   = 5'd12;
    localparam logic [4:0] MSG_RETURN_REPLY = 5'd13;
    localparam logic [4:0] MSG_DOWN_ACK     = 5'd14;
    localparam logic [4:0] MSG_INV_UPD_ACK  = 5'd15;
    localparam logic [4:0] MSG_INV_ACK      = 5'd16;
    localparam logic [4:0] MSG_PURGE_ACK    = 5'd17;

    // Routes
    localparam logic [1:0] ROUTE_REPLY = 2'd0;
    localparam logic [1:0] ROUTE_LOWER = 2'd1;
    localparam logic [1:0] ROUTE_UPPER = 2'd2;

    typedef struct packed {
        logic [3:0]           kind;
        logic [ADDR_BITS-1:0] address;
    } fvc_in_t;

    typedef struct packed {
        logic [1:0]           route;
        logic [4:0]           message;
        logic [ADDR_BITS-1:0] out_address;
        logic                 last;
    } fvc_out_t;

    function automatic fvc_out_t make_res(input logic [1:0] route, input logic [4:0] message,
                                          input logic [ADDR_BITS-1:0] addr,
                                          input logic last);
        fvc_out_t r;
        r.route       = route;
        r.message     = message;
        r.out_address = addr;
        r.last        = last;
        return r;
    endfunction

endpackage

### sv/fvc_tag_store.sv
// Tag array of the victim cache with one read port and the shared tag comparator.
// Depends on fvc_pkg for sizes.
module fvc_tag_store (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [fvc_pkg::IDX_W-1:0]       wr_idx,
    input  logic [fvc_pkg::ADDR_BITS-1:0]   wr_tag,
    input  logic [fvc_pkg::IDX_W-1:0]       rd_idx,
    input  logic [fvc_pkg::ADDR_BITS-1:0]   cmp_tag,
    output logic [fvc_pkg::ADDR_BITS-1:0]   rd_tag,
    output logic                            rd_match
);

    logic [fvc_pkg::ADDR_BITS-1:0] tag_reg [fvc_pkg::MAX_ENTRIES];

    // tags hold no reset: an entry is only looked at once its valid bit is set
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_reg[wr_idx] <= wr_tag;
        end
    end

    assign rd_tag   = tag_reg[rd_idx];
    assign rd_match = (rd_tag == cmp_tag);

endmodule

### sv/fifo_victim_cache_unit.sv
// Fully associative FIFO victim cache: lookup sequencer, entry state and result queue.
// Depends on fvc_pkg and fvc_tag_store.
// Enabled: a scan of every entry through one comparator and an update state, first result (if any) in the
// state after it; the next request is accepted only after every result of the last, m_ready stalls included.
// Disabled: result the cycle after acceptance. Unknown kinds: dropped.
// Reset (aresetn low, synchronous) empties the cache and restores register defaults.
module fifo_victim_cache_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  fvc_pkg::fvc_in_t                s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fvc_pkg::fvc_out_t               m_payload,
    input  logic                            cfg_wr_en,
    input  logic [fvc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fvc_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int IW = fvc_pkg::IDX_W;
    localparam int CW = fvc_pkg::COUNT_W;
    localparam int AW = fvc_pkg::ADDR_BITS;
    localparam int NE = fvc_pkg::MAX_ENTRIES;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_EMIT_A = 3'd3;
    localparam logic [2:0] ST_EMIT_B = 3'd4;

    logic [2:0] state_reg, state_next;

    logic       enable_reg;
    logic [4:0] capacity_reg;
    logic [3:0] line_shift_reg;

    logic [NE-1:0] valid_reg, valid_next;
    logic [NE-1:0] dirty_reg, dirty_next;
    logic [IW-1:0] age_reg  [NE];
    logic [IW-1:0] age_next [NE];
    logic [CW-1:0] count_reg, count_next;

    logic [3:0]    kind_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] blk_reg;
    logic [IW-1:0] idx_reg;

    logic          hit_found_reg, old_found_reg, free_found_reg;
    logic [IW-1:0] hit_idx_reg, old_idx_reg, free_idx_reg;
    logic [AW-1:0] old_tag_reg;

    fvc_pkg::fvc_out_t res_a_reg, res_b_reg, res_a, res_b;
    logic              two_reg;
    logic [1:0]        nres;

    logic [AW-1:0] line_mask;
    logic [AW-1:0] rd_tag;
    logic          rd_match;
    logic          s_fire;

    // update controls for the execute cycle
    logic          drop_en, ins_en, set_dirty_en, set_dirty_val, ins_dirty;
    logic [IW-1:0] drop_idx, ins_idx;
    logic [IW-1:0] drop_age;
    logic [CW-1:0] cap_sat, count_drop;
    logic          hit_dirty, old_dirty;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = (state_reg == ST_EMIT_A) || (state_reg == ST_EMIT_B);
    assign m_payload = (state_reg == ST_EMIT_B) ? res_b_reg : res_a_reg;
    assign line_mask = {AW{1'b1}} << line_shift_reg;

    fvc_tag_store u_tags (
        .aclk     (aclk),
        .wr_en    (ins_en),
        .wr_idx   (ins_idx),
        .wr_tag   (blk_reg),
        .rd_idx   (idx_reg),
        .cmp_tag  (blk_reg),
        .rd_tag   (rd_tag),
        .rd_match (rd_match)
    );

    assign hit_dirty = dirty_reg[hit_idx_reg];
    assign old_dirty = dirty_reg[old_idx_reg];

    always_comb begin
        if (capacity_reg == 5'd0) begin
            cap_sat = CW'(1);
        end else if (CW'(capacity_reg) > CW'(NE)) begin
            cap_sat = CW'(NE);
        end else begin
            cap_sat = CW'(capacity_reg);
        end
    end

    // decide results and entry updates from the scan outcome
    always_comb begin
        res_a         = fvc_pkg::make_res(fvc_pkg::ROUTE_REPLY, 5'(kind_reg), addr_reg, 1'b1);
        res_b         = fvc_pkg::make_res(fvc_pkg::ROUTE_REPLY, fvc_pkg::MSG_PURGE_ACK,
                                          addr_reg, 1'b1);
        nres          = 2'd0;
        drop_en       = 1'b0;
        drop_idx      = hit_idx_reg;
        ins_en        = 1'b0;
        ins_idx       = free_idx_reg;
        ins_dirty     = (kind_reg != fvc_pkg::KIND_EVICT_CLEAN);
        set_dirty_en  = 1'b0;
        set_dirty_val = 1'b0;
        if (state_reg == ST_EXEC) begin
            case (kind_reg) inside
                fvc_pkg::KIND_READ, fvc_pkg::KIND_WRITE, fvc_pkg::KIND_UPGRADE: begin
                    nres = 2'd1;
                    if (!hit_found_reg) begin
                        res_a.route = fvc_pkg::ROUTE_LOWER;
                    end else begin
                        drop_en = 1'b1;
                        if (hit_dirty) begin
                            res_a.message = fvc_pkg::MSG_MISS_DIRTY;
                        end else if (kind_reg == fvc_pkg::KIND_WRITE) begin
                            res_a.route   = fvc_pkg::ROUTE_LOWER;
                            res_a.message = fvc_pkg::MSG_UPGRADE;
                        end else begin
                            res_a.message = fvc_pkg::MSG_MISS_REPLY;
                        end
                    end
                end
                fvc_pkg::KIND_EVICT_CLEAN, fvc_pkg::KIND_EVICT_WR,
                fvc_pkg::KIND_EVICT_DIRTY: begin
                    if (hit_found_reg) begin
                        set_dirty_en  = 1'b1;
                        set_dirty_val = ins_dirty;
                    end else begin
                        // write back the oldest entry when full; insert at the lowest free or freed slot
                        if (count_reg >= cap_sat && old_found_reg) begin
                            nres     = 2'd1;
                            drop_en  = 1'b1;
                            drop_idx = old_idx_reg;
                            res_a    = fvc_pkg::make_res(fvc_pkg::ROUTE_LOWER,
                                           old_dirty ? fvc_pkg::MSG_EVICT_DIRTY
                                                     : fvc_pkg::MSG_EVICT_CLEAN,
                                           old_tag_reg, 1'b1);
                            ins_en   = 1'b1;
                            if (free_found_reg && free_idx_reg < old_idx_reg) begin
                                ins_idx = free_idx_reg;
                            end else begin
                                ins_idx = old_idx_reg;
                            end
                        end else begin
                            ins_en = free_found_reg;
                        end
                    end
                end
                default: begin
                    nres = 2'd1;
                    if (!hit_found_reg) begin
                        res_a.route = fvc_pkg::ROUTE_UPPER;
                    end else begin
                        case (kind_reg)
                            fvc_pkg::KIND_RETURN: begin
                                res_a.message = fvc_pkg::MSG_RETURN_REPLY;
                            end
                            fvc_pkg::KIND_DOWNGRADE: begin
                                set_dirty_en  = 1'b1;
                                res_a.message = fvc_pkg::MSG_DOWN_ACK;
                            end
                            fvc_pkg::KIND_INVALIDATE: begin
                                drop_en       = 1'b1;
                                res_a.message = hit_dirty ? fvc_pkg::MSG_INV_UPD_ACK
                                                          : fvc_pkg::MSG_INV_ACK;
                            end
                            default: begin
                                // purge: write back the block, then acknowledge
                                nres    = 2'd2;
                                drop_en = 1'b1;
                                res_a   = fvc_pkg::make_res(fvc_pkg::ROUTE_LOWER,
                                              hit_dirty ? fvc_pkg::MSG_EVICT_DIRTY
                                                        : fvc_pkg::MSG_EVICT_CLEAN,
                                              blk_reg, 1'b0);
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign drop_age   = age_reg[drop_idx];
    assign count_drop = (drop_en && count_reg != '0) ? count_reg - CW'(1) : count_reg;

    always_comb begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        age_next   = age_reg;
        count_next = count_reg;
        if (set_dirty_en) begin
            dirty_next[hit_idx_reg] = set_dirty_val;
        end
        if (drop_en) begin
            for (int j = 0; j < NE; j++) begin
                if (valid_reg[j] && age_reg[j] > drop_age) begin
                    age_next[j] = age_reg[j] - IW'(1);
                end
            end
            valid_next[drop_idx] = 1'b0;
            dirty_next[drop_idx] = 1'b0;
            age_next[drop_idx]   = '0;
            count_next           = count_drop;
        end
        if (ins_en) begin
            valid_next[ins_idx] = 1'b1;
            dirty_next[ins_idx] = ins_dirty;
            age_next[ins_idx]   = IW'(count_drop);
            count_next          = count_drop + CW'(1);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_payload.kind <= fvc_pkg::KIND_PURGE_DATA) begin
                    state_next = enable_reg ? ST_SCAN : ST_EMIT_A;
                end
            end
            ST_SCAN: begin
                if (idx_reg == IW'(NE - 1)) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = (nres == 2'd0) ? ST_IDLE : ST_EMIT_A;
            end
            ST_EMIT_A: begin
                if (m_ready) begin
                    state_next = two_reg ? ST_EMIT_B : ST_IDLE;
                end
            end
            ST_EMIT_B: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            enable_reg     <= 1'b0;
            capacity_reg   <= 5'd16;
            line_shift_reg <= 4'd6;
            valid_reg      <= '0;
            dirty_reg      <= '0;
            count_reg      <= '0;
            for (int j = 0; j < NE; j++) begin
                age_reg[j] <= '0;
            end
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            count_reg <= count_next;
            age_reg   <= age_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    fvc_pkg::CFG_ENABLE:     enable_reg     <= cfg_wdata[0];
                    fvc_pkg::CFG_CAPACITY:   capacity_reg   <= cfg_wdata;
                    fvc_pkg::CFG_LINE_SHIFT: line_shift_reg <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    // request capture, scan bookkeeping and result queue
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            kind_reg       <= s_payload.kind;
            addr_reg       <= s_payload.address;
            blk_reg        <= s_payload.address & line_mask;
            idx_reg        <= '0;
            hit_found_reg  <= 1'b0;
            old_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            two_reg        <= 1'b0;
            // disabled: pass the request straight on
            res_a_reg      <= fvc_pkg::make_res(
                                  (s_payload.kind <= fvc_pkg::KIND_EVICT_DIRTY)
                                      ? fvc_pkg::ROUTE_LOWER : fvc_pkg::ROUTE_UPPER,
                                  5'(s_payload.kind), s_payload.address, 1'b1);
        end
        if (state_reg == ST_SCAN) begin
            idx_reg <= idx_reg + IW'(1);
            if (!hit_found_reg && valid_reg[idx_reg] && rd_match) begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= idx_reg;
            end
            if (!old_found_reg && valid_reg[idx_reg] && age_reg[idx_reg] == '0) begin
                old_found_reg <= 1'b1;
                old_idx_reg   <= idx_reg;
                old_tag_reg   <= rd_tag;
            end
            if (!free_found_reg && !valid_reg[idx_reg]) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
        end
        if (state_reg == ST_EXEC) begin
            res_a_reg <= res_a;
            res_b_reg <= res_b;
            two_reg   <= (nres == 2'd2);
        end
    end

endmodule

### sv/fvc_checker.sv
// Port-level assertions for the FIFO victim cache, bound to the top level.
// Depends on fvc_pkg and fifo_victim_cache_unit.
module fvc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input fvc_pkg::fvc_in_t  s_payload,
    input logic              m_valid,
    input logic              m_ready,
    input fvc_pkg::fvc_out_t m_payload
);

    // one request at a time: never ready while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // a request of a known kind clears ready after acceptance; unknown kinds are dropped and not checked here
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_payload.kind <= fvc_pkg::KIND_PURGE_DATA) |=> !s_ready)
        else $error("ready held after accepting a request");

    a_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_payload.last) |=> (m_valid && m_payload.last))
        else $error("second result missing or not marked last");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
        else $error("stalled result changed");

endmodule

bind fifo_victim_cache_unit fvc_checker u_fvc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
